>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the RTL files; only the top-level module includes them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked on clk, quiet during reset.
`define RMQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same, with an implication written out.
`define RMQ_ASSERT_IMPL(lbl, ante, cons, msg) \
    `RMQ_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

>>> hdl/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// Widths, branch codes and side-band types for the matrix-to-quaternion block.
// ----------------------------------------------------------------------------
package rmq_pkg;

    localparam int WORD_BITS = 16;
    localparam int FRAC      = WORD_BITS - 2;

    // root argument (sum of three words plus one), signed
    localparam int ARG_BITS  = WORD_BITS + 2;
    // root fits in WORD_BITS-1 bits, radicand in twice that
    localparam int SQ_BITS   = WORD_BITS - 1;
    localparam int RAD_BITS  = 2 * SQ_BITS;
    // numerators: sum of two words, signed
    localparam int NUM_BITS  = WORD_BITS + 1;
    // dividend = |num| << FRAC, divisor = 4 * root
    localparam int DVD_BITS  = NUM_BITS + FRAC;
    localparam int DVS_BITS  = SQ_BITS + 2;
    localparam int QUO_BITS  = WORD_BITS;

    typedef enum logic [1:0] {
        CASE_TRACE = 2'd0,
        CASE_X     = 2'd1,
        CASE_Y     = 2'd2,
        CASE_Z     = 2'd3
    } case_t;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic signed [NUM_BITS-1:0]  num_t;

    // after branch select, carried alongside the root pipeline
    typedef struct packed {
        case_t sel;
        logic  clamp;
        num_t  n0;
        num_t  n1;
        num_t  n2;
    } side_a_t;

    // carried alongside the dividers
    typedef struct packed {
        case_t              sel;
        logic               flag;
        logic [SQ_BITS-1:0] root;
        logic [2:0]         neg;
        logic [2:0]         nz;
    } side_b_t;

    localparam word_t WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

endpackage

>>> hdl/rmq_if.sv
// ----------------------------------------------------------------------------
// rmq_mat_if / rmq_quat_if
// Valid/ready channels for matrix input words and quaternion result words.
// ----------------------------------------------------------------------------
interface rmq_mat_if;
    import rmq_pkg::*;
    logic  valid;
    logic  ready;
    word_t r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2;

    modport source (output valid, r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2,
                    input ready);
    modport sink   (input valid, r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, r2c2,
                    output ready);
endinterface

interface rmq_quat_if;
    import rmq_pkg::*;
    logic       valid;
    logic       ready;
    word_t      quat_x, quat_y, quat_z, quat_w;
    logic [1:0] case_taken;
    logic       saturated;

    modport source (output valid, quat_x, quat_y, quat_z, quat_w, case_taken, saturated,
                    input ready);
    modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, case_taken, saturated,
                    output ready);
endinterface

>>> hdl/rmq_sqrt.sv
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined digit-by-digit integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module rmq_sqrt
    import rmq_pkg::*;
(
    input  logic                clk,
    input  logic                en,
    input  logic [RAD_BITS-1:0] rad,
    output logic [SQ_BITS-1:0]  root
);

    localparam int REMW = SQ_BITS + 3;

    logic [RAD_BITS-1:0] v_reg    [SQ_BITS];
    logic [REMW-1:0]     rem_reg  [SQ_BITS];
    logic [SQ_BITS-1:0]  root_reg [SQ_BITS];

    for (genvar k = 0; k < SQ_BITS; k++) begin : g_stage
        logic [RAD_BITS-1:0] v_in;
        logic [REMW-1:0]     rem_in;
        logic [SQ_BITS-1:0]  root_in;
        logic [REMW-1:0]     rem_t;
        logic [REMW-1:0]     trial;
        logic                take;

        if (k == 0) begin : g_first
            assign v_in    = rad;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign v_in    = v_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
        end

        assign rem_t = {rem_in[REMW-3:0], v_in[RAD_BITS-1 -: 2]};
        assign trial = {1'b0, root_in, 2'b01};
        assign take  = rem_t >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[k]    <= {v_in[RAD_BITS-3:0], 2'b00};
                rem_reg[k]  <= take ? rem_t - trial : rem_t;
                root_reg[k] <= {root_in[SQ_BITS-2:0], take};
            end
        end
    end

    assign root = root_reg[SQ_BITS-1];

endmodule

>>> hdl/rmq_div.sv
// ----------------------------------------------------------------------------
// rmq_div
// Pipelined restoring divider: range check stage, then one quotient bit per
// stage. ovf is set when the quotient does not fit QUO_BITS bits.
// ----------------------------------------------------------------------------
module rmq_div
    import rmq_pkg::*;
(
    input  logic                clk,
    input  logic                en,
    input  logic [DVD_BITS-1:0] dvd,
    input  logic [DVS_BITS-1:0] dvs,
    output logic [QUO_BITS-1:0] quo,
    output logic                ovf
);

    logic [DVS_BITS-1:0] rem_reg [QUO_BITS+1];
    logic [QUO_BITS-1:0] low_reg [QUO_BITS+1];
    logic [DVS_BITS-1:0] d_reg   [QUO_BITS+1];
    logic [QUO_BITS-1:0] q_reg   [QUO_BITS+1];
    logic                ovf_reg [QUO_BITS+1];

    logic [DVD_BITS-QUO_BITS-1:0] hi;
    logic                         hi_ovf;

    assign hi     = dvd[DVD_BITS-1:QUO_BITS];
    assign hi_ovf = {{(DVS_BITS+QUO_BITS-DVD_BITS){1'b0}}, hi} >= dvs;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= hi_ovf ? '0 : DVS_BITS'(hi);
            low_reg[0] <= dvd[QUO_BITS-1:0];
            d_reg[0]   <= dvs;
            q_reg[0]   <= '0;
            ovf_reg[0] <= hi_ovf;
        end
    end

    for (genvar j = 0; j < QUO_BITS; j++) begin : g_stage
        logic [DVS_BITS:0] rem_t;
        logic              take;

        assign rem_t = {rem_reg[j], low_reg[j][QUO_BITS-1-j]};
        assign take  = rem_t >= {1'b0, d_reg[j]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j+1] <= take ? DVS_BITS'(rem_t - {1'b0, d_reg[j]})
                                     : DVS_BITS'(rem_t);
                low_reg[j+1] <= low_reg[j];
                d_reg[j+1]   <= d_reg[j];
                q_reg[j+1]   <= {q_reg[j][QUO_BITS-2:0], take};
                ovf_reg[j+1] <= ovf_reg[j];
            end
        end
    end

    assign quo = q_reg[QUO_BITS];
    assign ovf = ovf_reg[QUO_BITS];

endmodule

>>> hdl/rotation_matrix_to_quaternion.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Shepperd conversion of a Q2.14 rotation matrix to a Q2.14 quaternion.
// ----------------------------------------------------------------------------
// Accepts one matrix word per clock unless stalled and returns one quaternion word
// per matrix, in order. The stages are one for branch select, one per root bit in
// the square-root pipeline, a range check plus one per quotient bit in the three
// parallel dividers, and the output register. The whole pipeline advances
// whenever the output register is empty or being taken, so a stalled sink holds
// every word in place.
`include "assert_macros.svh"

module rotation_matrix_to_quaternion
    import rmq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    rmq_mat_if.sink    mat,
    rmq_quat_if.source quat
);

    localparam int DEPTH = SQ_BITS + QUO_BITS + 3;

    logic             en;
    logic [DEPTH-1:0] vld_reg;

    assign en        = !vld_reg[DEPTH-1] || quat.ready;
    assign mat.ready = en;
    assign quat.valid = vld_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], mat.valid};
        end
    end

    // ---------------- branch select ----------------
    logic signed [ARG_BITS-1:0] a, b, c, tr, arg_next;
    logic signed [ARG_BITS-1:0] one;
    num_t    s31, s26, s75, d75, d26, d31;
    side_a_t sa_next;

    assign one = ARG_BITS'(1) <<< FRAC;

    always_comb
    begin
        a   = ARG_BITS'(mat.r0c0);
        b   = ARG_BITS'(mat.r1c1);
        c   = ARG_BITS'(mat.r2c2);
        tr  = a + b + c;
        s31 = NUM_BITS'(mat.r1c0) + NUM_BITS'(mat.r0c1);
        s26 = NUM_BITS'(mat.r0c2) + NUM_BITS'(mat.r2c0);
        s75 = NUM_BITS'(mat.r2c1) + NUM_BITS'(mat.r1c2);
        d75 = NUM_BITS'(mat.r2c1) - NUM_BITS'(mat.r1c2);
        d26 = NUM_BITS'(mat.r0c2) - NUM_BITS'(mat.r2c0);
        d31 = NUM_BITS'(mat.r1c0) - NUM_BITS'(mat.r0c1);
        // numerators in ascending order of the slots not taken by the root
        priority if (tr > 0)
        begin
            sa_next.sel = CASE_TRACE;
            arg_next    = tr + one;
            sa_next.n0  = d75;
            sa_next.n1  = d26;
            sa_next.n2  = d31;
        end
        else if (a > b && a > c)
        begin
            sa_next.sel = CASE_X;
            arg_next    = a - b - c + one;
            sa_next.n0  = s31;
            sa_next.n1  = s26;
            sa_next.n2  = d75;
        end
        else if (b > c)
        begin
            sa_next.sel = CASE_Y;
            arg_next    = b - a - c + one;
            sa_next.n0  = s31;
            sa_next.n1  = s75;
            sa_next.n2  = d26;
        end
        else
        begin
            sa_next.sel = CASE_Z;
            arg_next    = c - a - b + one;
            sa_next.n0  = s26;
            sa_next.n1  = s75;
            sa_next.n2  = d31;
        end
        sa_next.clamp = arg_next < 0;
    end

    logic signed [ARG_BITS-1:0] arg_reg;
    side_a_t                    sa_reg [SQ_BITS+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            arg_reg   <= arg_next;
            sa_reg[0] <= sa_next;
            for (int k = 1; k <= SQ_BITS; k++)
            begin
                sa_reg[k] <= sa_reg[k-1];
            end
        end
    end

    // ---------------- square root ----------------
    logic [RAD_BITS-1:0] rad;
    logic [SQ_BITS-1:0]  root;

    // negative argument clamps to zero; shift makes the result 0.5*sqrt
    assign rad = arg_reg[ARG_BITS-1] ? '0
               : {1'b0, arg_reg[ARG_BITS-2:0], {(FRAC-2){1'b0}}};

    rmq_sqrt u_sqrt (
        .clk  (clk),
        .en   (en),
        .rad  (rad),
        .root (root)
    );

    // ---------------- dividers ----------------
    side_a_t             sa_end;
    num_t                nums [3];
    logic [DVD_BITS-1:0] dvd  [3];
    logic [DVS_BITS-1:0] dvs;
    logic [QUO_BITS-1:0] quo  [3];
    logic [2:0]          ovf;
    side_b_t             sb_next;
    side_b_t             sb_reg [QUO_BITS+1];

    assign sa_end  = sa_reg[SQ_BITS];
    assign nums[0] = sa_end.n0;
    assign nums[1] = sa_end.n1;
    assign nums[2] = sa_end.n2;
    assign dvs     = {root, 2'b00};

    always_comb
    begin
        sb_next.sel  = sa_end.sel;
        sb_next.flag = sa_end.clamp || (root == '0);
        sb_next.root = root;
        for (int i = 0; i < 3; i++)
        begin
            sb_next.neg[i] = nums[i][NUM_BITS-1];
            sb_next.nz[i]  = nums[i] != '0;
            dvd[i] = {(nums[i][NUM_BITS-1] ? NUM_BITS'(-nums[i]) : NUM_BITS'(nums[i])),
                      {FRAC{1'b0}}};
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_div
        rmq_div u_div (
            .clk (clk),
            .en  (en),
            .dvd (dvd[i]),
            .dvs (dvs),
            .quo (quo[i]),
            .ovf (ovf[i])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sb_reg[0] <= sb_next;
            for (int j = 1; j <= QUO_BITS; j++)
            begin
                sb_reg[j] <= sb_reg[j-1];
            end
        end
    end

    // ---------------- sign, saturate, place ----------------
    side_b_t    sb_end;
    word_t      comp [3];
    logic [2:0] sat;
    word_t      rw;
    word_t      qx_next, qy_next, qz_next, qw_next;
    logic       flag_next;

    assign sb_end = sb_reg[QUO_BITS];
    assign rw     = WORD_BITS'(sb_end.root);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sat[i] = 1'b0;
            if (sb_end.root == '0)
            begin
                comp[i] = !sb_end.nz[i] ? '0 : (sb_end.neg[i] ? WMIN : WMAX);
            end
            else if (sb_end.neg[i])
            begin
                sat[i]  = ovf[i] || (quo[i] > QUO_BITS'(WMIN));
                comp[i] = sat[i] ? WMIN : word_t'(-quo[i]);
            end
            else
            begin
                sat[i]  = ovf[i] || (quo[i] > QUO_BITS'(WMAX));
                comp[i] = sat[i] ? WMAX : word_t'(quo[i]);
            end
        end
        flag_next = sb_end.flag || (|sat);
        unique case (sb_end.sel)
            CASE_TRACE:
            begin
                qx_next = comp[0]; qy_next = comp[1]; qz_next = comp[2]; qw_next = rw;
            end
            CASE_X:
            begin
                qx_next = rw; qy_next = comp[0]; qz_next = comp[1]; qw_next = comp[2];
            end
            CASE_Y:
            begin
                qx_next = comp[0]; qy_next = rw; qz_next = comp[1]; qw_next = comp[2];
            end
            default:
            begin
                qx_next = comp[0]; qy_next = comp[1]; qz_next = rw; qw_next = comp[2];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quat.quat_x     <= qx_next;
            quat.quat_y     <= qy_next;
            quat.quat_z     <= qz_next;
            quat.quat_w     <= qw_next;
            quat.case_taken <= sb_end.sel;
            quat.saturated  <= flag_next;
        end
    end

    // ---------------- checks ----------------
    `RMQ_ASSERT(a_accept_enters, (mat.valid && mat.ready) |=> vld_reg[0], "accepted word lost")
    `RMQ_ASSERT(a_stall_holds, !en |=> $stable(vld_reg), "pipeline moved during stall")
    `RMQ_ASSERT_IMPL(a_trace_root, quat.valid && !quat.saturated && quat.case_taken == CASE_TRACE, quat.quat_w != '0, "zero root without saturation")
    `RMQ_ASSERT_IMPL(a_x_root, quat.valid && !quat.saturated && quat.case_taken == CASE_X, quat.quat_x != '0, "zero root without saturation")

endmodule
